>>> rtl/qsbp_pkg.sv
// ----------------------------------------------------------------------------
// QR segment bit packer package
// Shared codes, constants and the structs passed between the packer blocks.
// ----------------------------------------------------------------------------
package qsbp_pkg;

  // Segment modes
  localparam logic [1:0] MODE_NUMERIC = 2'd0;
  localparam logic [1:0] MODE_ALNUM   = 2'd1;
  localparam logic [1:0] MODE_BYTE    = 2'd2;
  localparam logic [1:0] MODE_KANJI   = 2'd3;

  // Request opcodes
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_FILL = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_CHAR  = 3'd1;
  localparam logic [2:0] ST_OVER_CAP  = 3'd2;
  localparam logic [2:0] ST_COUNT_BIG = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_SEGMENT_MODE      = 2'd0;
  localparam logic [1:0] CFG_LETTER_COUNT      = 2'd1;
  localparam logic [1:0] CFG_COUNT_FIELD_WIDTH = 2'd2;
  localparam logic [1:0] CFG_CAPACITY_BYTES    = 2'd3;

  // Fixed limits and pad bytes
  localparam int unsigned MAX_DATA_BYTES = 4095;
  localparam logic [4:0]  COUNT_WIDTH_MAX = 5'd16;
  localparam logic [7:0]  PAD_BYTE_A = 8'hEC;
  localparam logic [7:0]  PAD_BYTE_B = 8'h11;

  // Effective configuration seen by the packer
  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] letter_count;
    logic [4:0]  count_width;
    logic [11:0] cap;
  } cfg_t;

  // Group of up to five codewords caused by one request
  typedef struct packed {
    logic [39:0] bytes;
    logic [2:0]  cnt;
    logic [2:0]  status;
  } pkt_t;

endpackage

>>> rtl/qsbp_ifs.sv
// ----------------------------------------------------------------------------
// QR segment bit packer channels
// Valid/ready channels for requests in and codewords out.
// ----------------------------------------------------------------------------
interface qsbp_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] char_code;
  logic        is_final_char;

  modport source (output valid, opcode, char_code, is_final_char, input ready);
  modport sink   (input valid, opcode, char_code, is_final_char, output ready);
endinterface

interface qsbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] codeword;
  logic [2:0] status;
  logic       run_end;

  modport source (output valid, codeword, status, run_end, input ready);
  modport sink   (input valid, codeword, status, run_end, output ready);
endinterface

>>> rtl/qsbp_char_unit.sv
// ----------------------------------------------------------------------------
// QR segment bit packer character decoder
// Checks a character against the segment mode and maps it to its value.
// ----------------------------------------------------------------------------
module qsbp_char_unit import qsbp_pkg::*; (
  input  logic [1:0]  mode,
  input  logic [15:0] char_code,
  output logic        char_ok,
  output logic [12:0] char_val
);

  // Map an ASCII code to {valid, alphanumeric code}
  function automatic logic [6:0] alnum_code(input logic [15:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c inside {[16'h30:16'h39]}) begin
      r = {1'b1, 6'(c - 16'h30)};
    end else if (c inside {[16'h41:16'h5A]}) begin
      r = {1'b1, 6'(c - 16'h41 + 16'd10)};
    end else begin
      case (c)
        16'h20:  r = {1'b1, 6'd36};
        16'h24:  r = {1'b1, 6'd37};
        16'h25:  r = {1'b1, 6'd38};
        16'h2A:  r = {1'b1, 6'd39};
        16'h2B:  r = {1'b1, 6'd40};
        16'h2D:  r = {1'b1, 6'd41};
        16'h2E:  r = {1'b1, 6'd42};
        16'h2F:  r = {1'b1, 6'd43};
        16'h3A:  r = {1'b1, 6'd44};
        default: r = 7'd0;
      endcase
    end
    return r;
  endfunction

  logic [6:0]  aln;
  logic [15:0] sub;
  logic [12:0] kanji_val;

  assign aln = alnum_code(char_code);

  // Compact a kanji code: high byte times 0xC0 plus low byte
  always_comb begin
    if (char_code inside {[16'h8140:16'h9FFC]}) begin
      sub = char_code - 16'h8140;
    end else begin
      sub = char_code - 16'hC140;
    end
    kanji_val = 13'(13'(sub[13:8]) * 13'h0C0 + 13'(sub[7:0]));
  end

  // Select check and value by mode
  always_comb begin
    char_ok  = 1'b0;
    char_val = 13'd0;
    case (mode)
      MODE_NUMERIC: begin
        char_ok  = char_code inside {[16'h30:16'h39]};
        char_val = 13'(char_code[3:0]);
      end
      MODE_ALNUM: begin
        char_ok  = aln[6];
        char_val = 13'(aln[5:0]);
      end
      MODE_BYTE: begin
        char_ok  = char_code[15:8] == 8'd0;
        char_val = 13'(char_code[7:0]);
      end
      MODE_KANJI: begin
        char_ok  = (char_code inside {[16'h8140:16'h9FFC]}) ||
                   (char_code inside {[16'hE040:16'hEBBF]});
        char_val = kanji_val;
      end
      default: begin
        char_ok  = 1'b0;
        char_val = 13'd0;
      end
    endcase
  end

endmodule

>>> rtl/qsbp_packer.sv
// ----------------------------------------------------------------------------
// QR segment bit packer core
// Registers a request, packs its bits against the segment state and hands
// the finished codewords on as one packet.
// ----------------------------------------------------------------------------
module qsbp_packer import qsbp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  qsbp_in_if.sink    in_ch,
  output logic       pkt_valid,
  output pkt_t       pkt,
  input  logic       pkt_ready
);

  // Place n bits of v, MSB first, at bit offset p of a left-aligned word
  function automatic logic [47:0] put_field(input logic [47:0] w, input logic [5:0] p,
                                            input logic [15:0] v, input logic [4:0] n);
    logic [16:0] mask;
    logic [15:0] vm;
    logic [6:0]  sh;
    mask = (17'd1 << n) - 17'd1;
    vm   = v & mask[15:0];
    sh   = 7'd48 - 7'(p) - 7'(n);
    return w | (48'(vm) << sh);
  endfunction

  // Input register
  logic        in_v_r;
  logic        in_op_r;
  logic [15:0] in_ch_r;
  logic        in_fin_r;

  // Segment state
  logic [6:0]  lo_r, lo_nxt;
  logic [2:0]  pend_r, pend_nxt;
  logic [9:0]  gv_r, gv_nxt;
  logic [1:0]  gf_r, gf_nxt;
  logic        hdr_r, hdr_nxt;
  logic [11:0] be_r, be_nxt;
  logic        phase_r, phase_nxt;
  logic        closed_r, closed_nxt;

  logic        char_ok;
  logic [12:0] char_val;
  logic        count_big;
  logic        fire;

  logic [47:0] word;
  logic [5:0]  pos;
  logic [9:0]  gv;
  logic [2:0]  gf;
  logic [13:0] prod_num;
  logic [15:0] prod_aln;
  logic [15:0] used;
  logic [14:0] capbits;
  logic [14:0] room;
  logic [2:0]  term;
  logic [2:0]  nb;

  qsbp_char_unit u_char (
    .mode      (cfg.mode),
    .char_code (in_ch_r),
    .char_ok   (char_ok),
    .char_val  (char_val)
  );

  assign count_big = !hdr_r && (cfg.count_width < COUNT_WIDTH_MAX) &&
                     ((cfg.letter_count >> cfg.count_width) != 16'd0);
  assign capbits   = {cfg.cap, 3'b000};

  // Pack the held request against the current state
  always_comb begin
    word       = {lo_r, 41'd0};
    pos        = {3'd0, pend_r};
    gv         = gv_r;
    gf         = {1'b0, gf_r};
    prod_num   = 14'd0;
    prod_aln   = 16'd0;
    used       = 16'd0;
    room       = 15'd0;
    term       = 3'd0;
    nb         = 3'd0;
    lo_nxt     = lo_r;
    pend_nxt   = pend_r;
    gv_nxt     = gv_r;
    gf_nxt     = gf_r;
    hdr_nxt    = hdr_r;
    be_nxt     = be_r;
    phase_nxt  = phase_r;
    closed_nxt = closed_r;
    pkt_valid  = 1'b0;
    pkt.bytes  = 40'd0;
    pkt.cnt    = 3'd1;
    pkt.status = ST_OK;

    if (in_v_r) begin
      if (in_op_r == OP_FILL) begin
        // Fill request: ignored until the segment is closed
        if (closed_r) begin
          pkt_valid = 1'b1;
          if (be_r >= cfg.cap) begin
            pkt.status = ST_FULL;
          end else begin
            pkt.bytes = {(phase_r ? PAD_BYTE_B : PAD_BYTE_A), 32'd0};
            phase_nxt = ~phase_r;
            be_nxt    = be_r + 12'd1;
          end
        end
      end else if (closed_r) begin
        pkt_valid  = 1'b1;
        pkt.status = ST_FULL;
      end else if (count_big) begin
        pkt_valid  = 1'b1;
        pkt.status = ST_COUNT_BIG;
      end else if (!char_ok) begin
        pkt_valid  = 1'b1;
        pkt.status = ST_BAD_CHAR;
      end else begin
        // Segment header ahead of the first character
        if (!hdr_r) begin
          word = put_field(word, pos, 16'(4'b0001 << cfg.mode), 5'd4);
          pos  = pos + 6'd4;
          word = put_field(word, pos, cfg.letter_count, cfg.count_width);
          pos  = pos + 6'(cfg.count_width);
        end

        // Character grouping per mode
        case (cfg.mode)
          MODE_NUMERIC: begin
            prod_num = 14'(gv) * 14'd10 + 14'(char_val[3:0]);
            gv       = prod_num[9:0];
            gf       = gf + 3'd1;
            if (gf >= 3'd3) begin
              word = put_field(word, pos, 16'(gv), 5'd10);
              pos  = pos + 6'd10;
              gv   = 10'd0;
              gf   = 3'd0;
            end
          end
          MODE_ALNUM: begin
            if (gf != 3'd0) begin
              prod_aln = 16'(gv) * 16'd45 + 16'(char_val[5:0]);
              word     = put_field(word, pos, prod_aln, 5'd11);
              pos      = pos + 6'd11;
              gv       = 10'd0;
              gf       = 3'd0;
            end else begin
              gv = 10'(char_val[5:0]);
              gf = 3'd1;
            end
          end
          MODE_BYTE: begin
            word = put_field(word, pos, 16'(char_val[7:0]), 5'd8);
            pos  = pos + 6'd8;
          end
          default: begin
            word = put_field(word, pos, 16'(char_val), 5'd13);
            pos  = pos + 6'd13;
          end
        endcase

        // Flush an open group on the last character
        if (in_fin_r && gf != 3'd0) begin
          if (cfg.mode == MODE_NUMERIC) begin
            word = put_field(word, pos, 16'(gv), (gf == 3'd1) ? 5'd4 : 5'd7);
            pos  = pos + ((gf == 3'd1) ? 6'd4 : 6'd7);
          end else if (cfg.mode == MODE_ALNUM) begin
            word = put_field(word, pos, 16'(gv), 5'd6);
            pos  = pos + 6'd6;
          end
          gv = 10'd0;
          gf = 3'd0;
        end

        used = {1'b0, be_r, 3'b000} + 16'(pos);
        if (used > 16'(capbits)) begin
          pkt_valid  = 1'b1;
          pkt.status = ST_OVER_CAP;
        end else begin
          hdr_nxt = 1'b1;
          // Terminator within capacity, then zero pad to a byte boundary
          if (in_fin_r) begin
            room = capbits - used[14:0];
            term = (room < 15'd4) ? room[2:0] : 3'd4;
            pos  = pos + 6'(term);
            if (pos[2:0] != 3'd0) begin
              pos = {pos[5:3] + 3'd1, 3'b000};
            end
            closed_nxt = 1'b1;
          end
          nb       = pos[5:3];
          pend_nxt = pos[2:0];
          be_nxt   = be_r + 12'(nb);
          gv_nxt   = gv;
          gf_nxt   = gf[1:0];
          case (nb)
            3'd0:    lo_nxt = word[47:41];
            3'd1:    lo_nxt = word[39:33];
            3'd2:    lo_nxt = word[31:25];
            3'd3:    lo_nxt = word[23:17];
            3'd4:    lo_nxt = word[15:9];
            3'd5:    lo_nxt = word[7:1];
            default: lo_nxt = 7'd0;
          endcase
          pkt_valid = nb != 3'd0;
          pkt.bytes = word[47:8];
          pkt.cnt   = nb;
        end
      end
    end
  end

  // Advance when the result side can take the packet, or none is made
  assign fire        = in_v_r && (!pkt_valid || pkt_ready);
  assign in_ch.ready = !in_v_r || fire;

  // Input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_op_r  <= in_ch.opcode;
      in_ch_r  <= in_ch.char_code;
      in_fin_r <= in_ch.is_final_char;
    end
  end

  // Commit the segment state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r     <= 7'd0;
      pend_r   <= 3'd0;
      gv_r     <= 10'd0;
      gf_r     <= 2'd0;
      hdr_r    <= 1'b0;
      be_r     <= 12'd0;
      phase_r  <= 1'b0;
      closed_r <= 1'b0;
    end else if (fire) begin
      lo_r     <= lo_nxt;
      pend_r   <= pend_nxt;
      gv_r     <= gv_nxt;
      gf_r     <= gf_nxt;
      hdr_r    <= hdr_nxt;
      be_r     <= be_nxt;
      phase_r  <= phase_nxt;
      closed_r <= closed_nxt;
    end
  end

endmodule

>>> rtl/qsbp_serializer.sv
// ----------------------------------------------------------------------------
// QR segment bit packer output serializer
// Holds one codeword packet and presents its codewords one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module qsbp_serializer import qsbp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pkt_valid,
  input  pkt_t       pkt,
  output logic       pkt_ready,
  qsbp_out_if.source out_ch
);

  logic       pk_v_r;
  pkt_t       pk_r;
  logic [2:0] idx_r;
  logic       last;
  logic       take;

  assign out_ch.valid   = pk_v_r;
  assign out_ch.status  = pk_r.status;
  assign out_ch.run_end = idx_r == (pk_r.cnt - 3'd1);

  // Pick the current codeword, first one in the top byte
  always_comb begin
    case (idx_r)
      3'd0:    out_ch.codeword = pk_r.bytes[39:32];
      3'd1:    out_ch.codeword = pk_r.bytes[31:24];
      3'd2:    out_ch.codeword = pk_r.bytes[23:16];
      3'd3:    out_ch.codeword = pk_r.bytes[15:8];
      3'd4:    out_ch.codeword = pk_r.bytes[7:0];
      default: out_ch.codeword = 8'd0;
    endcase
  end

  assign take      = out_ch.valid && out_ch.ready;
  assign last      = take && out_ch.run_end;
  assign pkt_ready = !pk_v_r || last;

  // Load a new packet or step through the held one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pk_v_r <= 1'b0;
      idx_r  <= 3'd0;
    end else if (pkt_valid && pkt_ready) begin
      pk_v_r <= 1'b1;
      idx_r  <= 3'd0;
    end else if (last) begin
      pk_v_r <= 1'b0;
    end else if (take) begin
      idx_r <= idx_r + 3'd1;
    end
  end

  // Packet payload
  always_ff @(posedge clk) begin
    if (pkt_valid && pkt_ready) begin
      pk_r <= pkt;
    end
  end

endmodule

>>> rtl/qr_segment_bit_packer_unit.sv
// Flow: a request is registered in the input register and packed there; its
// codewords enter the serializer and go out one per cycle while out is ready.
// Throughput: one request per cycle while requests make no codeword; a request
// that makes k codewords holds the byte-wide output port until its last is taken.
// Reset: synchronous, active low; clears segment state, pipeline valids and
// returns the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// QR segment bit packer unit
// Packs one QR data segment into 8-bit data codewords with header,
// terminator, bit padding and 0xEC/0x11 fill bytes.
// ----------------------------------------------------------------------------
module qr_segment_bit_packer_unit import qsbp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  qsbp_in_if.sink     in_ch,
  qsbp_out_if.source  out_ch
);

  logic [1:0]  mode_r;
  logic [15:0] count_r;
  logic [4:0]  cwidth_r;
  logic [11:0] cap_r;
  cfg_t        cfg;
  logic        pkt_valid;
  pkt_t        pkt;
  logic        pkt_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_NUMERIC;
      count_r  <= 16'd0;
      cwidth_r <= 5'd10;
      cap_r    <= 12'd19;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEGMENT_MODE:      mode_r   <= cfg_wdata[1:0];
        CFG_LETTER_COUNT:      count_r  <= cfg_wdata;
        CFG_COUNT_FIELD_WIDTH: cwidth_r <= cfg_wdata[4:0];
        CFG_CAPACITY_BYTES:    cap_r    <= cfg_wdata[11:0];
        default:               mode_r   <= mode_r;
      endcase
    end
  end

  // Saturate the count width and clamp the capacity
  always_comb begin
    cfg.mode         = mode_r;
    cfg.letter_count = count_r;
    cfg.count_width  = (cwidth_r > COUNT_WIDTH_MAX) ? COUNT_WIDTH_MAX : cwidth_r;
    cfg.cap          = (32'(cap_r) > 32'(MAX_DATA_BYTES)) ? 12'(MAX_DATA_BYTES) : cap_r;
  end

  qsbp_packer u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .pkt_valid (pkt_valid),
    .pkt       (pkt),
    .pkt_ready (pkt_ready)
  );

  qsbp_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .pkt_valid (pkt_valid),
    .pkt       (pkt),
    .pkt_ready (pkt_ready),
    .out_ch    (out_ch)
  );

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// QR segment bit packer unit testbench
// Opens with a directed script of header checks, rejected characters, extreme
// codes and mode changes, then feeds random characters over many register
// settings and ends by closing the segment and draining the fill bytes. Every
// codeword is checked against a built-in packer model of the segment.
// ----------------------------------------------------------------------------
module testbench;
  import qsbp_pkg::*;

  localparam int RANDOM_CHARS = 270;
  localparam int SETTLE       = 6;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD    = 120;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int REPORT_CAP   = 40;

  // One codeword as seen on the result channel
  typedef struct packed {
    logic [7:0] codeword;
    logic [2:0] status;
    logic       run_end;
  } word_t;

  // One line of the directed script: a register write or a request
  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;
  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic        op;
    logic [15:0] data;
    logic        fin;
    logic        typed;
    logic [2:0]  t_st;
    logic [7:0]  t_cw;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  qsbp_in_if  in_req();
  qsbp_out_if out_cw();

  qr_segment_bit_packer_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_req),
    .out_ch    (out_cw)
  );

  // Register copy, at reset values
  logic [1:0]  m_mode  = MODE_NUMERIC;
  logic [15:0] m_count = 16'd0;
  logic [4:0]  m_cw    = 5'd10;
  logic [11:0] m_cap   = 12'd19;

  // Segment state of the packer model
  logic [47:0] acc       = '0;
  int unsigned pend      = 0;
  int unsigned gval      = 0;
  int unsigned gfill     = 0;
  int unsigned bytes_out = 0;
  bit          hdr_sent  = 1'b0;
  bit          closed    = 1'b0;
  bit          pad_b     = 1'b0;

  word_t fresh_words[$];
  word_t pending_words[$];
  int    mismatches   = 0;
  int    chars_sent   = 0;
  bit    calm         = 1'b0;
  bit    squeeze_req  = 1'b0;
  bit    squeeze_done = 1'b0;
  row_t  script[$];

  // Clock and cycle limit
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("[qr_segment_bit_packer_unit] ERROR");
        $finish;
      end
    end
  end

  function automatic word_t mk_word(input logic [7:0] cw, input logic [2:0] st,
                                    input logic re);
    word_t w;
    w.codeword = cw;
    w.status   = st;
    w.run_end  = re;
    return w;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < REPORT_CAP) $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Map a character to its value in the given mode; return 0 if not encodable
  function automatic bit char_value(input logic [1:0] mode, input logic [15:0] ch,
                                    output int unsigned val);
    int unsigned sub;
    val = 0;
    case (mode)
      MODE_NUMERIC: begin
        if (ch < 16'h30 || ch > 16'h39) return 1'b0;
        val = ch - 16'h30;
      end
      MODE_ALNUM: begin
        if (ch >= 16'h30 && ch <= 16'h39) val = ch - 16'h30;
        else if (ch >= 16'h41 && ch <= 16'h5A) val = ch - 16'h37;
        else begin
          case (ch)
            16'h20: val = 36;  // space
            16'h24: val = 37;  // $
            16'h25: val = 38;  // %
            16'h2A: val = 39;  // *
            16'h2B: val = 40;  // +
            16'h2D: val = 41;  // -
            16'h2E: val = 42;  // .
            16'h2F: val = 43;  // /
            16'h3A: val = 44;  // :
            default: return 1'b0;
          endcase
        end
      end
      MODE_BYTE: begin
        if (ch > 16'hFF) return 1'b0;
        val = ch;
      end
      default: begin
        if (ch >= 16'h8140 && ch <= 16'h9FFC) sub = ch - 16'h8140;
        else if (ch >= 16'hE040 && ch <= 16'hEBBF) sub = ch - 16'hC140;
        else return 1'b0;
        val = (sub >> 8) * 32'hC0 + (sub & 32'hFF);
      end
    endcase
    return 1'b1;
  endfunction

  // Append n bits, MSB first, to the bit accumulator
  function automatic void shift_in(input int unsigned value, input int unsigned n);
    acc  = (acc << n) | 48'(value & ((32'd1 << n) - 32'd1));
    pend += n;
  endfunction

  function automatic void reject(input logic [2:0] st);
    fresh_words.push_back(mk_word(8'h00, st, 1'b1));
  endfunction

  // Advance the segment model by one request; codewords go to fresh_words
  function automatic void pack_request(input logic op, input logic [15:0] ch,
                                       input logic fin);
    int unsigned cap_lim, capbits, cnt_w, val, used, room, k;
    logic [47:0] s_acc;
    int unsigned s_pend, s_gv, s_gf;
    word_t w;
    fresh_words.delete();
    cap_lim = (m_cap < MAX_DATA_BYTES) ? m_cap : MAX_DATA_BYTES;
    capbits = cap_lim * 8;
    cnt_w   = (m_cw > COUNT_WIDTH_MAX) ? COUNT_WIDTH_MAX : m_cw;

    // Fill bytes: ignored while open, alternate pads up to capacity
    if (op == OP_FILL) begin
      if (!closed) return;
      if (bytes_out >= cap_lim) begin
        reject(ST_FULL);
        return;
      end
      fresh_words.push_back(mk_word(pad_b ? PAD_BYTE_B : PAD_BYTE_A, ST_OK, 1'b1));
      pad_b = ~pad_b;
      bytes_out++;
      return;
    end

    if (closed) begin
      reject(ST_FULL);
      return;
    end
    if (!hdr_sent && cnt_w < 16 && m_count >= (32'd1 << cnt_w)) begin
      reject(ST_COUNT_BIG);
      return;
    end
    if (!char_value(m_mode, ch, val)) begin
      reject(ST_BAD_CHAR);
      return;
    end

    s_acc = acc;
    s_pend = pend;
    s_gv = gval;
    s_gf = gfill;

    // Mode indicator and count field ahead of the first character
    if (!hdr_sent) begin
      shift_in(32'd1 << m_mode, 4);
      shift_in(m_count, cnt_w);
    end

    case (m_mode)
      MODE_NUMERIC: begin
        gval = (gval * 10 + val) & 32'h3FF;
        gfill++;
        if (gfill >= 3) begin
          shift_in(gval, 10);
          gval = 0;
          gfill = 0;
        end
      end
      MODE_ALNUM: begin
        if (gfill != 0) begin
          shift_in(gval * 45 + val, 11);
          gval = 0;
          gfill = 0;
        end else begin
          gval = val;
          gfill = 1;
        end
      end
      MODE_BYTE: shift_in(val, 8);
      default:   shift_in(val, 13);
    endcase

    // Flush the open group; byte and kanji drop a stale one
    if (fin && gfill != 0) begin
      if (m_mode == MODE_NUMERIC) shift_in(gval, (gfill == 1) ? 4 : 7);
      else if (m_mode == MODE_ALNUM) shift_in(gval, 6);
      gval = 0;
      gfill = 0;
    end

    used = bytes_out * 8 + pend;
    if (used > capbits) begin
      acc = s_acc;
      pend = s_pend;
      gval = s_gv;
      gfill = s_gf;
      reject(ST_OVER_CAP);
      return;
    end
    hdr_sent = 1'b1;

    // Terminator within capacity, then zero pad to a byte boundary
    if (fin) begin
      room = capbits - used;
      shift_in(0, (room < 4) ? room : 4);
      if ((pend & 7) != 0) shift_in(0, 8 - (pend & 7));
      closed = 1'b1;
    end

    k = 0;
    while (pend >= 8 && k < 5) begin
      fresh_words.push_back(mk_word(8'((acc >> (pend - 8)) & 48'hFF), ST_OK, 1'b0));
      pend -= 8;
      bytes_out++;
      k++;
    end
    if (k > 0) begin
      w = fresh_words.pop_back();
      w.run_end = 1'b1;
      fresh_words.push_back(w);
    end
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one request after a random gap and hold it until accepted
  task automatic offer_request(input logic op, input logic [15:0] ch, input logic fin,
                               input bit typed, input word_t typed_word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req.valid         <= 1'b1;
    in_req.opcode        <= op;
    in_req.char_code     <= ch;
    in_req.is_final_char <= fin;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    pack_request(op, ch, fin);
    if (typed) pending_words.push_back(typed_word);
    else foreach (fresh_words[i]) pending_words.push_back(fresh_words[i]);
    @(negedge clk);
  endtask

  // Drop valid and wait for every expected codeword, then let the pipe settle
  task automatic wait_idle(input int settle);
    in_req.valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_SEGMENT_MODE:      m_mode  = data[1:0];
      CFG_LETTER_COUNT:      m_count = data;
      CFG_COUNT_FIELD_WIDTH: m_cw    = data[4:0];
      default:               m_cap   = data[11:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // A character the current mode accepts
  function automatic logic [15:0] pick_char(input logic [1:0] mode);
    logic [15:0] ch;
    int unsigned val;
    case (mode)
      MODE_NUMERIC: ch = 16'($urandom_range(16'h30, 16'h39));
      MODE_BYTE:    ch = 16'($urandom_range(0, 255));
      MODE_KANJI:   ch = $urandom_range(0, 1) ? 16'($urandom_range(16'h8140, 16'h9FFC))
                                              : 16'($urandom_range(16'hE040, 16'hEBBF));
      default: begin
        do ch = 16'($urandom_range(16'h20, 16'h5A));
        while (!char_value(MODE_ALNUM, ch, val));
      end
    endcase
    return ch;
  endfunction

  // One random request: mostly good characters, some noise and stray fills
  task automatic random_item();
    int r;
    int unsigned val;
    logic [15:0] ch;
    logic fin;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      offer_request(OP_FILL, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                    1'b0, '0);
    end else if (r < 85) begin
      offer_request(OP_CHAR, pick_char(m_mode), 1'b0, 1'b0, '0);
      chars_sent++;
    end else begin
      // Final flag only on characters that are sure to be rejected
      ch = 16'($urandom_range(0, 65535));
      fin = char_value(m_mode, ch, val) ? 1'b0 : 1'($urandom_range(0, 1));
      offer_request(OP_CHAR, ch, fin, 1'b0, '0);
      chars_sent++;
    end
  endtask

  // Check each accepted codeword against the oldest expectation
  always @(posedge clk) begin
    word_t want;
    if (rst_n && out_cw.valid && out_cw.ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected codeword %02h status %0d",
                                  out_cw.codeword, out_cw.status));
      end else begin
        want = pending_words.pop_front();
        if (out_cw.codeword !== want.codeword)
          report_mismatch($sformatf("codeword %02h, want %02h", out_cw.codeword,
                                    want.codeword));
        if (out_cw.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_cw.status, want.status));
        if (out_cw.run_end !== want.run_end)
          report_mismatch($sformatf("run_end %0b, want %0b", out_cw.run_end,
                                    want.run_end));
      end
    end
  end

  // Result side: random stalls, plus one long hold while requests keep coming
  initial begin : sink_side
    int stall_left;
    stall_left = 0;
    out_cw.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      out_cw.ready <= (stall_left == 0);
    end
  end

  // Stimulus
  initial begin : stimulus
    int phase, span, fills;
    bit probe;
    logic [1:0] mode_pick;
    int unsigned tight;

    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = CFG_SEGMENT_MODE;
    cfg_wdata            = 16'h0000;
    in_req.valid         = 1'b0;
    in_req.opcode        = OP_CHAR;
    in_req.char_code     = 16'h0000;
    in_req.is_final_char = 1'b0;

    script = '{
      // fill before the segment is closed is dropped
      '{ROW_REQ, CFG_SEGMENT_MODE, OP_FILL, 16'h0000, 1'b0, 1'b0, ST_OK, 8'h00},
      // count of 1024 overflows the 10-bit default field
      '{ROW_CFG, CFG_LETTER_COUNT, OP_CHAR, 16'd1024, 1'b0, 1'b0, ST_OK, 8'h00},
      '{ROW_REQ, CFG_SEGMENT_MODE, OP_CHAR, 16'h0037, 1'b1, 1'b1, ST_COUNT_BIG, 8'h00},
      // oversized field width saturates; zero capacity rejects everything
      '{ROW_CFG, CFG_COUNT_FIELD_WIDTH, OP_CHAR, 16'd31, 1'b0, 1'b0, ST_OK, 8'h00},
      '{ROW_CFG, CFG_CAPACITY_BYTES, OP_CHAR, 16'd0, 1'b0, 1'b0, ST_OK, 8'h00},
      '{ROW_REQ, CFG_SEGMENT_MODE, OP_CHAR, 16'h0037, 1'b0, 1'b1, ST_OVER_CAP, 8'h00},
      '{ROW_REQ, CFG_SEGMENT_MODE, OP_CHAR, 16'h002F, 1'b0, 1'b1, ST_BAD_CHAR, 8'h00},
      '{ROW_REQ, CFG_SEGMENT_MODE, OP_CHAR, 16'h003A, 1'b0, 1'b1, ST_BAD_CHAR, 8'h00},
      // one byte cannot hold the header
      '{ROW_CFG, CFG_CAPACITY_BYTES, OP_CHAR, 16'd1, 1'b0, 1'b0, ST_OK, 8'h00},
      '{ROW_REQ, CFG_SEGMENT_MODE, OP_CHAR, 16'h0030, 1'b0, 1'b1, ST_OVER_CAP, 8'h00},
      // widest header, largest capacity
      '{ROW_CFG, CFG_LETTER_COUNT, OP_CHAR, 16'hFFFF, 1'b0, 1'b0, ST_OK, 8'h00},
      '{ROW_CFG, CFG_COUNT_FIELD_WIDTH, OP_CHAR, 16'd16, 1'b0, 1'b0, ST_OK, 8'h00},
      '{ROW_CFG, CFG_CAPACITY_BYTES, OP_CHAR, 16'd4095, 1'b0, 1'b0, ST_OK, 8'h00},
      '{ROW_REQ, CFG_SEGMENT_MODE, OP_CHAR, 16'h0030, 1'b0, 1'b0, ST_OK, 8'h00},
      '{ROW_REQ, CFG_SEGMENT_MODE, OP_CHAR, 16'h0039, 1'b0, 1'b0, ST_OK, 8'h00},
      '{ROW_REQ, CFG_SEGMENT_MODE, OP_CHAR, 16'h0039, 1'b0, 1'b0, ST_OK, 8'h00},
      // alphanumeric edges
      '{ROW_CFG, CFG_SEGMENT_MODE, OP_CHAR, 16'(MODE_ALNUM), 1'b0, 1'b0, ST_OK, 8'h00},
      '{ROW_REQ, CFG_SEGMENT_MODE, OP_CHAR, 16'h0020, 1'b0, 1'b0, ST_OK, 8'h00},
      '{ROW_REQ, CFG_SEGMENT_MODE, OP_CHAR, 16'h003A, 1'b0, 1'b0, ST_OK, 8'h00},
      '{ROW_REQ, CFG_SEGMENT_MODE, OP_CHAR, 16'h005A, 1'b0, 1'b0, ST_OK, 8'h00},
      '{ROW_REQ, CFG_SEGMENT_MODE, OP_CHAR, 16'h0061, 1'b0, 1'b1, ST_BAD_CHAR, 8'h00},
      '{ROW_REQ, CFG_SEGMENT_MODE, OP_CHAR, 16'hFFFF, 1'b1, 1'b1, ST_BAD_CHAR, 8'h00},
      // byte edges
      '{ROW_CFG, CFG_SEGMENT_MODE, OP_CHAR, 16'(MODE_BYTE), 1'b0, 1'b0, ST_OK, 8'h00},
      '{ROW_REQ, CFG_SEGMENT_MODE, OP_CHAR, 16'h0000, 1'b0, 1'b0, ST_OK, 8'h00},
      '{ROW_REQ, CFG_SEGMENT_MODE, OP_CHAR, 16'h00FF, 1'b0, 1'b0, ST_OK, 8'h00},
      '{ROW_REQ, CFG_SEGMENT_MODE, OP_CHAR, 16'h0100, 1'b0, 1'b1, ST_BAD_CHAR, 8'h00},
      // kanji range ends and the holes around them
      '{ROW_CFG, CFG_SEGMENT_MODE, OP_CHAR, 16'(MODE_KANJI), 1'b0, 1'b0, ST_OK, 8'h00},
      '{ROW_REQ, CFG_SEGMENT_MODE, OP_CHAR, 16'h8140, 1'b0, 1'b0, ST_OK, 8'h00},
      '{ROW_REQ, CFG_SEGMENT_MODE, OP_CHAR, 16'h9FFC, 1'b0, 1'b0, ST_OK, 8'h00},
      '{ROW_REQ, CFG_SEGMENT_MODE, OP_CHAR, 16'hE040, 1'b0, 1'b0, ST_OK, 8'h00},
      '{ROW_REQ, CFG_SEGMENT_MODE, OP_CHAR, 16'hEBBF, 1'b0, 1'b0, ST_OK, 8'h00},
      '{ROW_REQ, CFG_SEGMENT_MODE, OP_CHAR, 16'h813F, 1'b0, 1'b1, ST_BAD_CHAR, 8'h00},
      '{ROW_REQ, CFG_SEGMENT_MODE, OP_CHAR, 16'hEBC0, 1'b0, 1'b1, ST_BAD_CHAR, 8'h00},
      '{ROW_REQ, CFG_SEGMENT_MODE, OP_CHAR, 16'hA000, 1'b0, 1'b1, ST_BAD_CHAR, 8'h00},
      // open a numeric group, then finish it in alphanumeric mode
      '{ROW_CFG, CFG_SEGMENT_MODE, OP_CHAR, 16'(MODE_NUMERIC), 1'b0, 1'b0, ST_OK, 8'h00},
      '{ROW_REQ, CFG_SEGMENT_MODE, OP_CHAR, 16'h0031, 1'b0, 1'b0, ST_OK, 8'h00},
      '{ROW_CFG, CFG_SEGMENT_MODE, OP_CHAR, 16'(MODE_ALNUM), 1'b0, 1'b0, ST_OK, 8'h00},
      '{ROW_REQ, CFG_SEGMENT_MODE, OP_CHAR, 16'h0041, 1'b0, 1'b0, ST_OK, 8'h00}
    };

    // Hold reset low, then release it
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed script
    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        wait_idle(SETTLE);
        write_reg(script[i].reg_idx, script[i].data);
      end else begin
        offer_request(script[i].op, script[i].data, script[i].fin, script[i].typed,
                      mk_word(script[i].t_cw, script[i].t_st, 1'b1));
      end
    end

    // Random phases, each under fresh register values
    phase = 0;
    while (chars_sent < RANDOM_CHARS) begin
      wait_idle(SETTLE);
      calm  = (phase == 1) || ($urandom_range(0, 4) == 0);
      probe = (phase > 2) && ($urandom_range(0, 3) == 0);
      write_reg(CFG_SEGMENT_MODE, 16'($urandom_range(0, 3)));
      write_reg(CFG_LETTER_COUNT, $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                                       : {16{1'($urandom_range(0, 1))}});
      write_reg(CFG_COUNT_FIELD_WIDTH, 16'($urandom_range(0, 31)));
      // A tight capacity pushes most characters over the edge
      write_reg(CFG_CAPACITY_BYTES, probe ? 16'(bytes_out) : 16'(MAX_DATA_BYTES));
      span = probe ? 6 : $urandom_range(8, 40);
      for (int i = 0; i < span; i++) begin
        if (phase == 1 && i == 3) squeeze_req = 1'b1;
        random_item();
      end
      phase++;
    end

    // Close the segment, growing capacity until the final character fits
    calm = 1'b0;
    tight = bytes_out + 1;
    do begin
      wait_idle(SETTLE);
      mode_pick = 2'($urandom_range(0, 3));
      write_reg(CFG_SEGMENT_MODE, 16'(mode_pick));
      write_reg(CFG_CAPACITY_BYTES, 16'(tight));
      offer_request(OP_CHAR, pick_char(mode_pick), 1'b1, 1'b0, '0);
      tight++;
    end while (!closed);

    // Drain the pad bytes, run past full, then knock on the closed segment
    fills = int'(m_cap) - int'(bytes_out) + 3;
    repeat (fills) offer_request(OP_FILL, 16'($urandom_range(0, 65535)), 1'b0, 1'b0, '0);
    offer_request(OP_CHAR, pick_char(m_mode), 1'b0, 1'b0, '0);
    offer_request(OP_CHAR, pick_char(m_mode), 1'b1, 1'b0, '0);

    wait_idle(DRAIN_CYCLES);
    if (mismatches == 0) begin
      $display("[qr_segment_bit_packer_unit] OK");
    end else begin
      $display("[qr_segment_bit_packer_unit] ERROR");
    end
    $finish;
  end

endmodule
